### rtl/ltr_pkg.sv
// Shared constants and types for the link third-row rebuild block.
// No dependencies; compiled first.
package ltr_pkg;

   localparam int PART_WIDTH_DEF = 32;
   localparam int FIELD_W = 64;
   localparam int NUM_COLS = 3;

   // direction codes selecting the phase rule
   localparam logic [1:0] DIR_T   = 2'd0;
   localparam logic [1:0] DIR_TX  = 2'd1;
   localparam logic [1:0] DIR_TXY = 2'd2;
   localparam logic [1:0] DIR_NONE = 2'd3;

   // per-stage advance enables shared by the lanes
   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } ltr_adv_type;

endpackage

### rtl/ltr_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on ltr_pkg.
interface ltr_req_if import ltr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] row0_col0;
   logic [FIELD_W-1:0] row0_col1;
   logic [FIELD_W-1:0] row0_col2;
   logic [FIELD_W-1:0] row1_col0;
   logic [FIELD_W-1:0] row1_col1;
   logic [FIELD_W-1:0] row1_col2;
   logic [1:0]         direction;
   logic               t_odd;
   logic               x_odd;
   logic               y_odd;

   modport source (
      output valid, row0_col0, row0_col1, row0_col2,
             row1_col0, row1_col1, row1_col2, direction, t_odd, x_odd, y_odd,
      input  ready
   );
   modport sink (
      input  valid, row0_col0, row0_col1, row0_col2,
             row1_col0, row1_col1, row1_col2, direction, t_odd, x_odd, y_odd,
      output ready
   );
endinterface

interface ltr_rsp_if import ltr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] row2_col0;
   logic [FIELD_W-1:0] row2_col1;
   logic [FIELD_W-1:0] row2_col2;

   modport source (
      output valid, row2_col0, row2_col1, row2_col2,
      input  ready
   );
   modport sink (
      input  valid, row2_col0, row2_col1, row2_col2,
      output ready
   );
endinterface

### rtl/ltr_lane.sv
// One column lane: eight products, paired differences with phase sign,
// then the full sum plus rounding half. Depends on ltr_pkg.
module ltr_lane import ltr_pkg::*; #(
   parameter int PART_WIDTH = PART_WIDTH_DEF
) (
   input  logic                              clock,
   input  ltr_adv_type                       adv,
   input  logic signed [PART_WIDTH-1:0]      ar_j,
   input  logic signed [PART_WIDTH-1:0]      ai_j,
   input  logic signed [PART_WIDTH-1:0]      ar_k,
   input  logic signed [PART_WIDTH-1:0]      ai_k,
   input  logic signed [PART_WIDTH-1:0]      br_j,
   input  logic signed [PART_WIDTH-1:0]      bi_j,
   input  logic signed [PART_WIDTH-1:0]      br_k,
   input  logic signed [PART_WIDTH-1:0]      bi_k,
   input  logic                              neg,
   output logic signed [2*PART_WIDTH+2:0]    re_sum,
   output logic signed [2*PART_WIDTH+2:0]    im_sum
);

   localparam int PW2  = 2 * PART_WIDTH;
   localparam int RW   = PW2 + 1;
   localparam int SW   = PW2 + 3;
   localparam int FRAC = PART_WIDTH - 2;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC - 1);

   // stage 1: products
   logic signed [PW2-1:0] prod_ff [8];
   logic signed [PW2-1:0] prod_in [8];
   logic                  neg_ff;
   // stage 2: signed differences
   logic signed [RW-1:0]  diff_ff [4];
   logic signed [RW-1:0]  diff_in [4];
   // stage 3: sums with rounding half
   logic signed [SW-1:0]  re_ff, re_in, im_ff, im_in;

   always_comb begin
      // r1 = ar_j*br_k - ar_k*br_j, r2 = ai_k*bi_j - ai_j*bi_k
      // i1 = ar_k*bi_j - ar_j*bi_k, i2 = ai_k*br_j - ai_j*br_k
      prod_in[0] = PW2'(ar_j) * PW2'(br_k);
      prod_in[1] = PW2'(ar_k) * PW2'(br_j);
      prod_in[2] = PW2'(ai_k) * PW2'(bi_j);
      prod_in[3] = PW2'(ai_j) * PW2'(bi_k);
      prod_in[4] = PW2'(ar_k) * PW2'(bi_j);
      prod_in[5] = PW2'(ar_j) * PW2'(bi_k);
      prod_in[6] = PW2'(ai_k) * PW2'(br_j);
      prod_in[7] = PW2'(ai_j) * PW2'(br_k);
   end

   always_comb begin
      for (int d = 0; d < 4; d++) begin
         // phase negation folds into the subtract order
         if (neg_ff) begin
            diff_in[d] = RW'(prod_ff[2*d+1]) - RW'(prod_ff[2*d]);
         end else begin
            diff_in[d] = RW'(prod_ff[2*d]) - RW'(prod_ff[2*d+1]);
         end
      end
   end

   assign re_in = SW'(diff_ff[0]) + SW'(diff_ff[1]) + HALF;
   assign im_in = SW'(diff_ff[2]) + SW'(diff_ff[3]) + HALF;

   always_ff @(posedge clock) begin
      if (adv.en1) begin
         prod_ff <= prod_in;
         neg_ff  <= neg;
      end
      if (adv.en2) begin
         diff_ff <= diff_in;
      end
      if (adv.en3) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   assign re_sum = re_ff;
   assign im_sum = im_ff;

endmodule

### rtl/ltr_merge.sv
// Output stage: floors and saturates the lane sums, packs the third row
// and holds it in the response register. Depends on ltr_pkg, ltr_if.
module ltr_merge import ltr_pkg::*; #(
   parameter int PART_WIDTH = PART_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           take,
   input  logic signed [2*PART_WIDTH+2:0] re_sum [NUM_COLS],
   input  logic signed [2*PART_WIDTH+2:0] im_sum [NUM_COLS],
   ltr_rsp_if.source                      rsp
);

   localparam int SW   = 2 * PART_WIDTH + 3;
   localparam int FRAC = PART_WIDTH - 2;
   localparam int QW   = SW - FRAC;

   logic               valid_ff, valid_in;
   logic [FIELD_W-1:0] row_ff [NUM_COLS];
   logic [FIELD_W-1:0] row_in [NUM_COLS];

   function automatic logic [PART_WIDTH-1:0] sat_part(input logic signed [SW-1:0] s);
      logic signed [QW-1:0] q;
      logic [QW-PART_WIDTH:0] hi;
      begin
         q  = QW'(s >>> FRAC);
         hi = q[QW-1:PART_WIDTH-1];
         if (hi == '0 || hi == '1) begin
            sat_part = q[PART_WIDTH-1:0];
         end else if (q[QW-1]) begin
            sat_part = {1'b1, {(PART_WIDTH-1){1'b0}}};
         end else begin
            sat_part = {1'b0, {(PART_WIDTH-1){1'b1}}};
         end
      end
   endfunction

   assign take = !valid_ff || rsp.ready;

   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         row_in[c] = FIELD_W'({sat_part(re_sum[c]), sat_part(im_sum[c])});
      end
      valid_in = take ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         row_ff <= row_in;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.row2_col0 = row_ff[0];
   assign rsp.row2_col1 = row_ff[1];
   assign rsp.row2_col2 = row_ff[2];

endmodule

### rtl/link_third_row_rebuild_core.sv
// Rebuilds the third row of a 3x3 complex link matrix from its first two
// rows, one transaction per clock while responses are taken. An accepted
// request passes the lane product, difference and sum registers and then
// the response register before its response is valid. Three column lanes
// each run a multiply, subtract, sum pipeline (eight PART_WIDTH x PART_WIDTH
// multipliers per lane) whose sums carry a rounding half; the output stage
// floors, saturates to signed Q2.(PART_WIDTH-2) and packs. Every stage moves
// on when its successor frees up, so bubbles are squeezed out while a response
// is stalled. Depends on ltr_pkg, ltr_if, ltr_lane and ltr_merge.
module link_third_row_rebuild_core import ltr_pkg::*; #(
   parameter int PART_WIDTH = PART_WIDTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   ltr_req_if.sink  req,
   ltr_rsp_if.source rsp
);

   localparam int SW = 2 * PART_WIDTH + 3;

   ltr_adv_type adv;
   logic        v1_ff, v2_ff, v3_ff;
   logic        v1_in, v2_in, v3_in;
   logic        take;
   logic        neg;

   logic signed [PART_WIDTH-1:0] a_re [NUM_COLS];
   logic signed [PART_WIDTH-1:0] a_im [NUM_COLS];
   logic signed [PART_WIDTH-1:0] b_re [NUM_COLS];
   logic signed [PART_WIDTH-1:0] b_im [NUM_COLS];
   logic signed [SW-1:0]         re_sum [NUM_COLS];
   logic signed [SW-1:0]         im_sum [NUM_COLS];

   always_comb begin
      a_re[0] = req.row0_col0[2*PART_WIDTH-1:PART_WIDTH];
      a_im[0] = req.row0_col0[PART_WIDTH-1:0];
      a_re[1] = req.row0_col1[2*PART_WIDTH-1:PART_WIDTH];
      a_im[1] = req.row0_col1[PART_WIDTH-1:0];
      a_re[2] = req.row0_col2[2*PART_WIDTH-1:PART_WIDTH];
      a_im[2] = req.row0_col2[PART_WIDTH-1:0];
      b_re[0] = req.row1_col0[2*PART_WIDTH-1:PART_WIDTH];
      b_im[0] = req.row1_col0[PART_WIDTH-1:0];
      b_re[1] = req.row1_col1[2*PART_WIDTH-1:PART_WIDTH];
      b_im[1] = req.row1_col1[PART_WIDTH-1:0];
      b_re[2] = req.row1_col2[2*PART_WIDTH-1:PART_WIDTH];
      b_im[2] = req.row1_col2[PART_WIDTH-1:0];
   end

   // staggered phase sign
   always_comb begin
      case (req.direction)
         DIR_T:    neg = req.t_odd;
         DIR_TX:   neg = req.t_odd ^ req.x_odd;
         DIR_TXY:  neg = req.t_odd ^ req.x_odd ^ req.y_odd;
         DIR_NONE: neg = 1'b0;
         default:  neg = 1'b0;
      endcase
   end

   always_comb begin
      adv.en3 = !v3_ff || take;
      adv.en2 = !v2_ff || adv.en3;
      adv.en1 = !v1_ff || adv.en2;
      v1_in   = adv.en1 ? req.valid : v1_ff;
      v2_in   = adv.en2 ? v1_ff : v2_ff;
      v3_in   = adv.en3 ? v2_ff : v3_ff;
   end

   assign req.ready = adv.en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
      localparam int J = (c + 1) % NUM_COLS;
      localparam int K = (c + 2) % NUM_COLS;
      ltr_lane #(
         .PART_WIDTH(PART_WIDTH)
      ) u_lane (
         .clock  (clock),
         .adv    (adv),
         .ar_j   (a_re[J]),
         .ai_j   (a_im[J]),
         .ar_k   (a_re[K]),
         .ai_k   (a_im[K]),
         .br_j   (b_re[J]),
         .bi_j   (b_im[J]),
         .br_k   (b_re[K]),
         .bi_k   (b_im[K]),
         .neg    (neg),
         .re_sum (re_sum[c]),
         .im_sum (im_sum[c])
      );
   end

   ltr_merge #(
      .PART_WIDTH(PART_WIDTH)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v3_ff),
      .take     (take),
      .re_sum   (re_sum),
      .im_sum   (im_sum),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> v1_ff)
      else $error("accepted transaction did not enter stage 1");
   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !adv.en3 |=> v2_ff)
      else $error("stage 2 dropped a transaction while blocked");
   a_merge_loads: assert property (@(posedge clock) disable iff (reset)
      v3_ff && take |=> rsp.valid)
      else $error("output stage did not load a finished transaction");
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !v1_ff && !v2_ff && !v3_ff && !rsp.valid)
      else $error("pipeline valid bits not cleared by reset");
`endif

endmodule
